>>> src/sme_pkg.sv
// shared types and constants for the stack machine execute block
// status codes, operation codes, queue entry and sequencer state
// no dependencies
`timescale 1ns / 1ps

package sme_pkg;

  localparam int DATA_BYTES_DEF  = 1024;
  localparam int STACK_BYTES_DEF = 1024;

  localparam logic [15:0] SEG_DATA  = 16'd512;
  localparam logic [15:0] SEG_STACK = 16'd514;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_MUL     = 3'd2,
    OP_ADD     = 3'd3,
    OP_END     = 3'd4,
    OP_PRELOAD = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_SEGMENT = 3'd1,
    STS_UNDER   = 3'd2,
    STS_OVER    = 3'd3,
    STS_RANGE   = 3'd4,
    STS_NOOP    = 3'd5
  } status_t;

  // one classified instruction waiting for the back end
  typedef struct packed {
    op_t          op;
    logic [2:0]   n;
    logic [9:0]   off;
    logic [31:0]  lv;
    status_t      pre;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_GATHER,
    BK_CALC,
    BK_FILL,
    BK_DONE
  } bk_state_t;

  function automatic logic [31:0] size_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

>>> src/sme_front.sv
// front end: classifies incoming instructions and queues them
// checks segment, size and address range; holds a two-entry queue
// depends on sme_pkg
`timescale 1ns / 1ps

module sme_front
  import sme_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [2:0]  size_bytes,
  input  logic [15:0] segment_base,
  input  logic [9:0]  address_offset,
  input  logic [31:0] load_value,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_take
);

  localparam int DW = $clog2(DATA_BYTES + 1);
  localparam int CW = ((DW > 10) ? DW : 10) + 1;

  cmd_t        cls;
  logic        size_ok;
  logic        range_ok;

  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        push;

  always_comb begin
    size_ok  = size_bytes inside {[3'd1:3'd4]};
    range_ok = (CW'(address_offset) + CW'(size_bytes)) <= CW'(DATA_BYTES);
    cls.n    = size_bytes;
    cls.off  = address_offset;
    cls.lv   = load_value;
    cls.op   = OP_END;
    cls.pre  = STS_OK;
    case (op_t'(mode))
      OP_PUSH, OP_POP: begin
        cls.op = op_t'(mode);
        if (segment_base != SEG_DATA) cls.pre = STS_SEGMENT;
        else if (!size_ok || !range_ok) cls.pre = STS_RANGE;
      end
      OP_MUL, OP_ADD: begin
        cls.op = op_t'(mode);
        if (segment_base != SEG_STACK) cls.pre = STS_SEGMENT;
        else if (!size_ok) cls.pre = STS_RANGE;
      end
      OP_PRELOAD: begin
        cls.op = OP_PRELOAD;
        if (!size_ok || !range_ok) cls.pre = STS_RANGE;
      end
      default: begin
        cls.op  = OP_END;
        cls.pre = STS_NOOP;
      end
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = q[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_take) count_next = count + 2'd1;
    else if (!push && q_take) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)   wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

endmodule

>>> src/sme_back.sv
// back end: stack pointer, data and stack memories, byte sequencer
// gathers operand bytes, computes, scatters result bytes, holds the result register
// depends on sme_pkg
`timescale 1ns / 1ps

module sme_back
  import sme_pkg::*;
#(
  parameter int DATA_BYTES  = DATA_BYTES_DEF,
  parameter int STACK_BYTES = STACK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic [2:0]  status,
  output logic [9:0]  stack_depth
);

  localparam int DAW = $clog2(DATA_BYTES);
  localparam int SAW = $clog2(STACK_BYTES);
  localparam int SPW = $clog2(STACK_BYTES + 1);
  localparam int PW  = SPW + 1;
  localparam int BW  = (SAW > DAW) ? SAW : DAW;

  logic [7:0] dmem [DATA_BYTES];
  logic [7:0] smem [STACK_BYTES];

  bk_state_t state, state_next;
  cmd_t      cmd;

  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_new;
  logic [63:0]    acc;
  logic [BW-1:0]  gbase;
  logic [BW-1:0]  fbase;
  logic           gsrc;   // 1: stack memory
  logic           fdst;   // 1: stack memory
  logic [3:0]     glen;
  logic [3:0]     rcnt;
  logic [2:0]     rk;
  logic           rpend;
  logic [1:0]     fcnt;
  logic [31:0]    wval;
  logic [31:0]    res;
  status_t        sts;

  // plan worked out in the check state
  status_t        p_sts;
  logic [SPW-1:0] p_sp;
  logic [BW-1:0]  p_gbase;
  logic [BW-1:0]  p_fbase;
  logic           p_gsrc;
  logic           p_fdst;
  logic [3:0]     p_glen;
  logic [PW-1:0]  sp_w;
  logic [PW-1:0]  n_w;
  logic [PW-1:0]  n2_w;

  logic           issue;
  logic [BW-1:0]  g_addr;
  logic [BW-1:0]  f_addr;
  logic [BW:0]    f_wide;
  logic           d_re, s_re, d_we, s_we;
  logic [7:0]     d_rdata, s_rdata, rdata;
  logic [7:0]     wbyte;
  logic [2:0]     slot;
  logic           gather_last;
  logic           fill_last;
  logic           out_load;
  logic [31:0]    op_a, op_b;
  logic [31:0]    calc;

  always_comb begin
    sp_w    = PW'(sp);
    n_w     = PW'(cmd.n);
    n2_w    = n_w << 1;
    p_sts   = cmd.pre;
    p_sp    = sp;
    p_gbase = BW'(cmd.off);
    p_fbase = BW'(cmd.off);
    p_gsrc  = 1'b0;
    p_fdst  = 1'b0;
    p_glen  = {1'b0, cmd.n};
    if (cmd.pre == STS_OK) begin
      case (cmd.op)
        OP_PUSH: begin
          p_fdst  = 1'b1;
          p_fbase = BW'(sp);
          if (sp_w + n_w > PW'(STACK_BYTES)) p_sts = STS_OVER;
          else p_sp = SPW'(sp_w + n_w);
        end
        OP_POP: begin
          p_gsrc  = 1'b1;
          p_gbase = BW'(sp_w - n_w);
          if (sp_w < n_w) p_sts = STS_UNDER;
          else p_sp = SPW'(sp_w - n_w);
        end
        OP_MUL, OP_ADD: begin
          p_gsrc  = 1'b1;
          p_fdst  = 1'b1;
          p_gbase = BW'(sp_w - n2_w);
          p_fbase = BW'(sp_w - n2_w);
          p_glen  = {cmd.n, 1'b0};
          if (sp_w < n2_w) p_sts = STS_UNDER;
          else p_sp = SPW'(sp_w - n_w);
        end
        default: begin
          // preload writes data memory only
          p_fdst = 1'b0;
        end
      endcase
    end
  end

  assign gather_last = rpend && ({1'b0, rk} == glen - 4'd1);
  assign fill_last   = ({1'b0, fcnt} == cmd.n - 3'd1);
  assign out_load    = (state == BK_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (q_valid) state_next = BK_CHECK;
      BK_CHECK: begin
        if (p_sts != STS_OK) state_next = BK_DONE;
        else if (cmd.op == OP_PRELOAD) state_next = BK_FILL;
        else state_next = BK_GATHER;
      end
      BK_GATHER: if (gather_last) state_next = BK_CALC;
      BK_CALC:   state_next = BK_FILL;
      BK_FILL:   if (fill_last) state_next = BK_DONE;
      BK_DONE:   if (out_load) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_take = (state == BK_IDLE) && q_valid;
    issue  = (state == BK_GATHER) && (rcnt < glen);
    d_re   = issue && !gsrc;
    s_re   = issue && gsrc;
    d_we   = (state == BK_FILL) && !fdst;
    s_we   = (state == BK_FILL) && fdst;
  end

  assign g_addr = BW'(gbase + BW'(rcnt));
  assign f_addr = BW'(fbase + BW'(fcnt));
  assign f_wide = (BW + 1)'(fbase) + (BW + 1)'(fcnt);
  assign wbyte  = wval[fcnt*8 +: 8];
  assign rdata  = gsrc ? s_rdata : d_rdata;
  // second operand bytes land in the upper word
  assign slot   = (rk < cmd.n) ? rk : 3'(rk - cmd.n + 3'd4);
  assign op_a   = acc[63:32];
  assign op_b   = acc[31:0];

  always_comb begin
    case (cmd.op)
      OP_MUL:  calc = (op_a * op_b) & size_mask(cmd.n);
      OP_ADD:  calc = (op_a + op_b) & size_mask(cmd.n);
      default: calc = op_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[f_addr[DAW-1:0]] <= wbyte;
    if (d_re) d_rdata <= dmem[g_addr[DAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[f_addr[SAW-1:0]] <= wbyte;
    if (s_re) s_rdata <= smem[g_addr[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_take) cmd <= q_cmd;
    if (state == BK_CHECK) begin
      sts    <= p_sts;
      sp_new <= p_sp;
      gbase  <= p_gbase;
      fbase  <= p_fbase;
      gsrc   <= p_gsrc;
      fdst   <= p_fdst;
      glen   <= p_glen;
      rcnt   <= 4'd0;
      fcnt   <= 2'd0;
      acc    <= 64'd0;
      res    <= 32'd0;
      wval   <= cmd.lv;
    end
    if (state == BK_GATHER) begin
      if (issue) rcnt <= rcnt + 4'd1;
      rk <= rcnt[2:0];
      if (rpend) acc[slot*8 +: 8] <= rdata;
    end
    if (state == BK_CALC) begin
      wval <= calc;
      res  <= calc;
    end
    if (state == BK_FILL) fcnt <= fcnt + 2'd1;
    if (out_load) begin
      result_value <= res;
      status       <= sts;
      stack_depth  <= 10'(sp_new);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      sp        <= '0;
      rpend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rpend <= issue;
      if (out_load) begin
        sp        <= sp_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_BYTES))
    else $error("stack pointer beyond stack size");

  a_sp_commit: assert property (@(posedge clk) disable iff (rst)
    (state != BK_DONE) |=> (sp == $past(sp)))
    else $error("stack pointer moved outside result hand-off");

  a_fill_stack_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FILL && fdst) |-> (f_wide < (BW + 1)'(STACK_BYTES)))
    else $error("stack write out of range");

  a_fill_data_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FILL && !fdst) |-> (f_wide < (BW + 1)'(DATA_BYTES)))
    else $error("data write out of range");

  a_gather_len: assert property (@(posedge clk) disable iff (rst)
    (state == BK_GATHER && rpend) |-> ({1'b0, rk} < glen))
    else $error("gathered byte beyond operand length");

endmodule

>>> src/stack_machine_execute_top.sv
// top level of the stack machine execute block
// channel  | dir | tdata fields (lsb first)
// s_axis   | in  | mode, size_bytes, segment_base, address_offset, load_value
// m_axis   | out | result_value, status, stack_depth
// one result per instruction
// the back end takes a new instruction only once the last result is loaded into the output register;
// its byte-wide memories read or write one byte per cycle
// two instructions queue in the front while the back works or stalls
// rst synchronous active high: stack pointer 0, memories undefined until written
// depends on sme_pkg, sme_front, sme_back
`timescale 1ns / 1ps

module stack_machine_execute_top
  import sme_pkg::*;
#(
  parameter int DATA_BYTES  = DATA_BYTES_DEF,
  parameter int STACK_BYTES = STACK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[2:0], size_bytes[5:3], segment_base[21:6], address_offset[31:22],
  // load_value[63:32]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_value[31:0], status[34:32], stack_depth[44:35], zero fill[47:45]
  output logic [47:0] m_tdata
);

  logic        q_valid;
  cmd_t        q_cmd;
  logic        q_take;
  logic [31:0] result_value;
  logic [2:0]  status;
  logic [9:0]  stack_depth;

  sme_front #(
    .DATA_BYTES (DATA_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .mode           (s_tdata[2:0]),
    .size_bytes     (s_tdata[5:3]),
    .segment_base   (s_tdata[21:6]),
    .address_offset (s_tdata[31:22]),
    .load_value     (s_tdata[63:32]),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_take         (q_take)
  );

  sme_back #(
    .DATA_BYTES  (DATA_BYTES),
    .STACK_BYTES (STACK_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_take       (q_take),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .result_value (result_value),
    .status       (status),
    .stack_depth  (stack_depth)
  );

  assign m_tdata = {3'b000, stack_depth, status, result_value};

endmodule

>>> tb/sv/stack_machine_execute_top_test.sv
// self-checking testbench for stack_machine_execute_top: directed corner cases, then random
// fill and drain runs of the stack with random idling on both streams
// depends on sme_pkg and the stack_machine_execute_top rtl
`timescale 1ns / 1ps

module stack_machine_execute_top_test;
  import sme_pkg::*;

  localparam int DATA_BYTES   = 1024;
  localparam int STACK_BYTES  = 1024;
  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]  mode;
    logic [2:0]  size;
    logic [15:0] seg;
    logic [9:0]  off;
    logic [31:0] lv;
  } instr_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
    logic [9:0]  depth;
  } outcome_t;

  class exec_scoreboard;
    logic [7:0] data_mem [DATA_BYTES];
    bit         data_set [DATA_BYTES];
    logic [7:0] stack_mem [STACK_BYTES];
    int         sp;
    outcome_t   due_outcomes [$];
    int         errors;
    int         op_count [8];
    int         status_count [6];
    int         full_hits;

    function new();
      sp = 0;
      errors = 0;
      full_hits = 0;
      foreach (data_set[i]) data_set[i] = 1'b0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    // true when every byte a read at off could touch has been written
    function bit bytes_loaded(int off, int cnt);
      for (int i = 0; i < cnt; i++) begin
        if (off + i < DATA_BYTES && !data_set[off + i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void apply_instr(instr_t it);
      outcome_t r;
      int n;
      int off;
      logic [31:0] a;
      logic [31:0] b;
      n = it.size;
      off = it.off;
      r.value = '0;
      r.status = STS_OK;
      op_count[it.mode]++;
      case (it.mode)
        OP_PUSH, OP_POP: begin
          if (it.seg != SEG_DATA) r.status = STS_SEGMENT;
          else if (n < 1 || n > 4 || off + n > DATA_BYTES) r.status = STS_RANGE;
          else if (it.mode == OP_PUSH) begin
            if (sp + n > STACK_BYTES) r.status = STS_OVER;
            else begin
              for (int i = 0; i < n; i++) begin
                r.value[8*i +: 8] = data_mem[off + i];
                stack_mem[sp + i] = data_mem[off + i];
              end
              sp += n;
            end
          end else if (sp < n) r.status = STS_UNDER;
          else begin
            sp -= n;
            for (int i = 0; i < n; i++) begin
              r.value[8*i +: 8] = stack_mem[sp + i];
              data_mem[off + i] = stack_mem[sp + i];
              data_set[off + i] = 1'b1;
            end
          end
        end
        OP_MUL, OP_ADD: begin
          if (it.seg != SEG_STACK) r.status = STS_SEGMENT;
          else if (n < 1 || n > 4) r.status = STS_RANGE;
          else if (sp < 2 * n) r.status = STS_UNDER;
          else begin
            a = '0;
            b = '0;
            for (int i = 0; i < n; i++) begin
              a[8*i +: 8] = stack_mem[sp - n + i];
              b[8*i +: 8] = stack_mem[sp - 2 * n + i];
            end
            r.value = (it.mode == OP_MUL) ? a * b : a + b;
            if (n < 4) r.value &= (32'h1 << (8 * n)) - 32'h1;
            sp -= n;
            for (int i = 0; i < n; i++) stack_mem[sp - n + i] = r.value[8*i +: 8];
          end
        end
        OP_PRELOAD: begin
          if (n < 1 || n > 4 || off + n > DATA_BYTES) r.status = STS_RANGE;
          else begin
            for (int i = 0; i < n; i++) begin
              data_mem[off + i] = it.lv[8*i +: 8];
              data_set[off + i] = 1'b1;
            end
          end
        end
        default: r.status = STS_NOOP;
      endcase
      // a completely full stack wraps the 10-bit depth to zero
      r.depth = sp[9:0];
      status_count[r.status]++;
      if (sp == STACK_BYTES) full_hits++;
      due_outcomes.push_back(r);
    endfunction

    function void check_result(logic [47:0] word);
      outcome_t e;
      if (due_outcomes.size() == 0) begin
        $error("result transaction with nothing expected: %h", word);
        errors++;
        return;
      end
      e = due_outcomes.pop_front();
      if (word[31:0] !== e.value) begin
        $error("result_value: expected %h, got %h", e.value, word[31:0]);
        errors++;
      end
      if (word[34:32] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, word[34:32]);
        errors++;
      end
      if (word[44:35] !== e.depth) begin
        $error("stack_depth: expected %0d, got %0d", e.depth, word[44:35]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  exec_scoreboard sb;
  int             sent = 0;
  int             received = 0;
  logic [9:0]     recent_off [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stack_machine_execute_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // random wait per transaction, with every fifth stretch of period items idle-free
  function automatic int idle_draw(int count, int period);
    if ((count / period) % 5 == 4) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [9:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 10'($urandom_range(0, 127));
    if (r < 95) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(1016, 1023));
  endfunction

  function automatic instr_t random_instr(bit filling);
    instr_t it;
    int pick;
    int cnt;
    bit ok;
    logic [9:0] cand;
    it.lv = $urandom();
    it.off = pick_offset();
    if ($urandom_range(0, 9) == 0) it.size = 3'($urandom_range(0, 7));
    else if (filling && $urandom_range(0, 1) == 1) it.size = 3'd4;
    else it.size = 3'($urandom_range(1, 4));
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 72 : 12)) it.mode = OP_PUSH;
    else if (pick < (filling ? 84 : 22)) it.mode = OP_PRELOAD;
    else if (pick < (filling ? 89 : 55)) it.mode = OP_POP;
    else if (pick < (filling ? 94 : 92)) it.mode = ($urandom_range(0, 1) == 1) ? OP_MUL : OP_ADD;
    else it.mode = 3'($urandom_range(4, 7));
    if (it.mode == OP_PUSH || it.mode == OP_POP) it.seg = SEG_DATA;
    else if (it.mode == OP_MUL || it.mode == OP_ADD) it.seg = SEG_STACK;
    else it.seg = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 11) == 0) it.seg = 16'($urandom_range(0, 65535));
    // a push may only read data bytes that were written before
    if (it.mode == OP_PUSH) begin
      cnt = (it.size >= 1 && it.size <= 4) ? int'(it.size) : 7;
      ok = 1'b0;
      for (int t = 0; t < 6 && !ok; t++) begin
        if (t < 4 && recent_off.size() > 0)
          cand = recent_off[$urandom_range(0, recent_off.size() - 1)];
        else
          cand = pick_offset();
        if (sb.bytes_loaded(cand, cnt)) begin
          it.off = cand;
          ok = 1'b1;
        end
      end
      if (!ok) it.mode = OP_PRELOAD;
    end
    if (it.mode == OP_PRELOAD || it.mode == OP_POP) begin
      recent_off.push_back(it.off);
      if (recent_off.size() > 32) void'(recent_off.pop_front());
    end
    return it;
  endfunction

  task automatic send_instr(instr_t it);
    int gap;
    gap = idle_draw(sent, 50);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {it.lv, it.off, it.seg, it.size, it.mode};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.apply_instr(it);
    sent++;
  endtask

  task automatic take_results();
    int gap;
    forever begin
      // one long hold-off lets the block back up and stall its input
      gap = (received == HOLD_AT) ? HOLD_CYCLES : idle_draw(received, 70);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
      received++;
    end
  endtask

  task automatic run_directed();
    send_instr(instr_t'{OP_POP, 3'd4, SEG_DATA, 10'd0, 32'd0});
    send_instr(instr_t'{OP_ADD, 3'd1, SEG_STACK, 10'd0, 32'd0});
    send_instr(instr_t'{OP_PRELOAD, 3'd4, 16'd0, 10'd0, 32'hFFFF_FFFF});
    send_instr(instr_t'{OP_PRELOAD, 3'd4, 16'hFFFF, 10'd4, 32'h0000_0000});
    send_instr(instr_t'{OP_PRELOAD, 3'd4, SEG_DATA, 10'd1020, 32'h89AB_CDEF});
    send_instr(instr_t'{OP_PRELOAD, 3'd4, SEG_DATA, 10'd1022, 32'h1111_1111});
    send_instr(instr_t'{OP_PRELOAD, 3'd0, SEG_DATA, 10'd8, 32'h2222_2222});
    send_instr(instr_t'{OP_PRELOAD, 3'd7, SEG_DATA, 10'd8, 32'h3333_3333});
    send_instr(instr_t'{OP_PRELOAD, 3'd3, SEG_DATA, 10'd8, 32'h1234_5678});
    send_instr(instr_t'{OP_PUSH, 3'd4, SEG_DATA, 10'd0, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd4, SEG_DATA, 10'd0, 32'd0});
    // all-ones squared wraps to one
    send_instr(instr_t'{OP_MUL, 3'd4, SEG_STACK, 10'd0, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd2, SEG_DATA, 10'd1022, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd4, SEG_DATA, 10'd1022, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd5, SEG_DATA, 10'd0, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd1, SEG_STACK, 10'd0, 32'd0});
    send_instr(instr_t'{OP_ADD, 3'd2, SEG_DATA, 10'd0, 32'd0});
    send_instr(instr_t'{OP_ADD, 3'd2, SEG_STACK, 10'd0, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd3, SEG_DATA, 10'd8, 32'd0});
    // pop narrower than the push takes the top byte as it lies
    send_instr(instr_t'{OP_POP, 3'd1, SEG_DATA, 10'd1023, 32'd0});
    send_instr(instr_t'{OP_POP, 3'd1, 16'd0, 10'd0, 32'd0});
    send_instr(instr_t'{OP_END, 3'd7, 16'hFFFF, 10'd1023, 32'hFFFF_FFFF});
    send_instr(instr_t'{3'd6, 3'd1, SEG_DATA, 10'd0, 32'd0});
    send_instr(instr_t'{3'd7, 3'd2, SEG_STACK, 10'd0, 32'd0});
    send_instr(instr_t'{OP_MUL, 3'd0, SEG_STACK, 10'd0, 32'd0});
    send_instr(instr_t'{OP_POP, 3'd4, SEG_DATA, 10'd1021, 32'd0});
    send_instr(instr_t'{OP_POP, 3'd3, SEG_DATA, 10'd12, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd1, SEG_DATA, 10'd0, 32'd0});
    send_instr(instr_t'{OP_PUSH, 3'd1, SEG_DATA, 10'd0, 32'd0});
    send_instr(instr_t'{OP_ADD, 3'd1, SEG_STACK, 10'd0, 32'd0});
  endtask

  // alternate push-heavy runs up to overflow with drain runs down to underflow
  task automatic run_random();
    bit filling;
    int phase_len;
    int mark;
    filling = 1'b1;
    phase_len = 0;
    mark = sb.status_count[STS_OVER];
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      send_instr(random_instr(filling));
      phase_len++;
      if (filling && (sb.status_count[STS_OVER] - mark >= 4 || phase_len > 600)) begin
        filling = 1'b0;
        phase_len = 0;
        mark = sb.status_count[STS_UNDER];
      end else if (!filling && ((sb.sp < 8 && sb.status_count[STS_UNDER] - mark >= 3)
                                || phase_len > 600)) begin
        filling = 1'b1;
        phase_len = 0;
        mark = sb.status_count[STS_OVER];
      end
    end
  endtask

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
      else idle_run++;
    end
    $display("[stack_machine_execute_top] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none
    run_directed();
    run_random();
    s_tvalid <= 1'b0;
    while (sb.due_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d instructions: push %0d, pop %0d, mul %0d, add %0d, preload %0d, no-op %0d",
             sent, sb.op_count[OP_PUSH], sb.op_count[OP_POP], sb.op_count[OP_MUL],
             sb.op_count[OP_ADD], sb.op_count[OP_PRELOAD],
             sb.op_count[OP_END] + sb.op_count[6] + sb.op_count[7]);
    $display("outcomes: ok %0d, segment %0d, underflow %0d, overflow %0d, range %0d, full stack %0d",
             sb.status_count[STS_OK], sb.status_count[STS_SEGMENT], sb.status_count[STS_UNDER],
             sb.status_count[STS_OVER], sb.status_count[STS_RANGE], sb.full_hits);
    if (sb.errors == 0) begin
      $display("[stack_machine_execute_top] OK");
    end else begin
      $display("[stack_machine_execute_top] ERROR");
    end
    $finish;
  end

endmodule
